>>> rtl/core/msstat_pkg.sv
// Package for the multichannel sample statistics block
// Holds widths, op codes and the controller/datapath command and status structs
// No dependencies
package msstat_pkg;

  localparam int DEF_CHANNELS   = 16;
  localparam int DEF_COUNT_BITS = 16;
  localparam int REPORT_MAX     = 16;

  localparam int VAL_W = 24;
  localparam int TAG_W = 32;
  localparam int CFG_W = 5;
  localparam int RCH_W = 4;
  localparam int OP_W  = 2;

  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic in_ready;
    logic upd;
    logic clr;
    logic k_clr;
    logic k_inc;
    logic mul_go;
    logic mul_sq;
    logic div_go;
    logic div_var;
    logic sqrt_go;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic            req_valid;
    logic [OP_W-1:0] req_op;
    logic            ch_ok;
    logic            busy;
    logic            out_free;
    logic            k_last;
  } stat_t;

endpackage

>>> rtl/core/msstat_in_if.sv
// Input item channel of the statistics block: valid/ready plus item fields
// Standalone, widths match msstat_pkg
interface msstat_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  channel;
  logic signed [23:0] sample_value;
  logic [31:0] time_tag;

  modport source(output valid, op, channel, sample_value, time_tag, input ready);
  modport sink(input valid, op, channel, sample_value, time_tag, output ready);
endinterface

>>> rtl/core/msstat_out_if.sv
// Result item channel of the statistics block: valid/ready plus result fields
// Standalone, widths match msstat_pkg
interface msstat_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  report_channel;
  logic signed [23:0] mean_value;
  logic [23:0] deviation;
  logic signed [23:0] largest_value;
  logic [31:0] largest_tag;
  logic signed [23:0] smallest_value;
  logic [31:0] smallest_tag;
  logic        no_samples;
  logic        overflowed;
  logic        last_result;

  modport source(output valid, report_channel, mean_value, deviation, largest_value,
                 largest_tag, smallest_value, smallest_tag, no_samples, overflowed,
                 last_result, input ready);
  modport sink(input valid, report_channel, mean_value, deviation, largest_value,
               largest_tag, smallest_value, smallest_tag, no_samples, overflowed,
               last_result, output ready);
endinterface

>>> rtl/core/msstat_ctrl.sv
// Controller state machine of the statistics block
// Sequences sample updates, clears and the per-channel report run; uses msstat_pkg
module msstat_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  msstat_pkg::stat_t st,
  output msstat_pkg::cmd_t  cmd
);
  import msstat_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_SMP   = 11'b000_0000_0010,
    S_RADDR = 11'b000_0000_0100,
    S_RLD   = 11'b000_0000_1000,
    S_MUL1  = 11'b000_0001_0000,
    S_MUL2  = 11'b000_0010_0000,
    S_DIVM  = 11'b000_0100_0000,
    S_DIVV  = 11'b000_1000_0000,
    S_SQRT  = 11'b001_0000_0000,
    S_ROUT  = 11'b010_0000_0000,
    S_SPARE = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.req_valid) begin
          case (st.req_op)
            OP_SAMPLE: begin
              if (st.ch_ok) begin
                state_nxt = S_SMP;
              end
            end
            OP_REPORT: begin
              cmd.k_clr = 1'b1;
              state_nxt = S_RADDR;
            end
            OP_CLEAR: begin
              cmd.clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_SMP: begin
        cmd.upd   = 1'b1;
        state_nxt = S_IDLE;
      end
      // entry data is registered in the cycle after the channel index moves
      S_RADDR: begin
        state_nxt = S_RLD;
      end
      S_RLD: begin
        cmd.mul_go = 1'b1;
        cmd.mul_sq = 1'b1;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        if (!st.busy) begin
          cmd.mul_go = 1'b1;
          state_nxt  = S_MUL2;
        end
      end
      S_MUL2: begin
        if (!st.busy) begin
          cmd.div_go = 1'b1;
          state_nxt  = S_DIVM;
        end
      end
      S_DIVM: begin
        if (!st.busy) begin
          cmd.div_go  = 1'b1;
          cmd.div_var = 1'b1;
          state_nxt   = S_DIVV;
        end
      end
      S_DIVV: begin
        if (!st.busy) begin
          cmd.sqrt_go = 1'b1;
          state_nxt   = S_SQRT;
        end
      end
      S_SQRT: begin
        if (!st.busy) begin
          state_nxt = S_ROUT;
        end
      end
      S_ROUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.k_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = S_RADDR;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/msstat_dp.sv
// Datapath of the statistics block: channel store, extremes, shared serial
// multiplier, divider and square root, output register; uses msstat_pkg and interfaces
module msstat_dp #(
  parameter int CHANNELS   = msstat_pkg::DEF_CHANNELS,
  parameter int COUNT_BITS = msstat_pkg::DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [msstat_pkg::CFG_W-1:0]  cfg_data,
  msstat_in_if.sink                     in_if,
  msstat_out_if.source                  out_if,
  input  msstat_pkg::cmd_t              cmd,
  output msstat_pkg::stat_t             st
);
  import msstat_pkg::*;

  localparam int SUM_W   = VAL_W + COUNT_BITS;
  localparam int SQ_W    = 2 * VAL_W + COUNT_BITS;
  localparam int NUM_W   = 2 * VAL_W + 2 * COUNT_BITS;
  localparam int DEN_W   = 2 * COUNT_BITS;
  localparam int STEP_W  = $clog2(NUM_W + 1);
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENT_W   = 1 + COUNT_BITS + SQ_W + SUM_W;
  localparam int REP_LIM = (CHANNELS < REPORT_MAX) ? CHANNELS : REPORT_MAX;
  localparam int RT_W    = VAL_W;
  localparam int SX_W    = 2 * RT_W;
  localparam int SR_W    = RT_W + 2;

  typedef enum logic [2:0] {
    U_MUL_SQ, U_MUL_MAG, U_DIV_MEAN, U_DIV_VAR, U_SQRT
  } unit_t;

  // configuration
  logic [CFG_W-1:0] active_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= CFG_W'(1);
    end else if (cfg_we) begin
      active_r <= cfg_data;
    end
  end

  // latched sample item
  logic                   accept;
  logic [CH_W-1:0]        smp_ch_r;
  logic signed [VAL_W-1:0] smp_val_r;
  logic [TAG_W-1:0]       smp_tag_r;
  logic [CH_W-1:0]        rep_ch_r;

  assign accept      = in_if.valid && cmd.in_ready;
  assign in_if.ready = cmd.in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_ch_r  <= CH_W'(in_if.channel);
      smp_val_r <= in_if.sample_value;
      smp_tag_r <= in_if.time_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_ch_r <= '0;
    end else if (cmd.k_clr) begin
      rep_ch_r <= '0;
    end else if (cmd.k_inc) begin
      rep_ch_r <= rep_ch_r + CH_W'(1);
    end
  end

  // channel store with per-entry valid bits; invalid entries read as zero
  logic [ENT_W-1:0]    mem [CHANNELS];
  logic [ENT_W-1:0]    rd_data_r;
  logic                vld_rd_r;
  logic [CHANNELS-1:0] valid_r;
  logic [CH_W-1:0]     rd_addr;
  logic [ENT_W-1:0]    rd_ent;
  logic [ENT_W-1:0]    wr_data;

  assign rd_addr = cmd.in_ready ? CH_W'(in_if.channel) : rep_ch_r;

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      mem[smp_ch_r] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    vld_rd_r  <= valid_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      valid_r <= '0;
    end else if (cmd.upd) begin
      valid_r[smp_ch_r] <= 1'b1;
    end
  end

  logic signed [SUM_W-1:0] e_sum;
  logic [SQ_W-1:0]         e_sq;
  logic [COUNT_BITS-1:0]   e_cnt;
  logic                    e_ovf;
  logic                    e_neg;
  logic [SUM_W-1:0]        e_mag;

  assign rd_ent = vld_rd_r ? rd_data_r : '0;
  assign e_sum  = signed'(rd_ent[SUM_W-1:0]);
  assign e_sq   = rd_ent[SUM_W +: SQ_W];
  assign e_cnt  = rd_ent[SUM_W + SQ_W +: COUNT_BITS];
  assign e_ovf  = rd_ent[ENT_W-1];
  assign e_neg  = e_sum[SUM_W-1];
  assign e_mag  = e_neg ? SUM_W'(-e_sum) : SUM_W'(e_sum);

  // sample update
  logic signed [2*VAL_W-1:0] vsq;
  logic                      sat;
  logic signed [SUM_W-1:0]   new_sum;
  logic [SQ_W-1:0]           new_sq;

  assign vsq     = smp_val_r * smp_val_r;
  assign sat     = (e_cnt == '1);
  assign new_sum = e_sum + SUM_W'(smp_val_r);
  assign new_sq  = e_sq + SQ_W'(unsigned'(vsq));
  assign wr_data = sat ? {1'b1, e_cnt, e_sq, e_sum}
                       : {e_ovf, e_cnt + COUNT_BITS'(1), new_sq, new_sum};

  logic signed [VAL_W-1:0] peak_r, trough_r;
  logic [TAG_W-1:0]        peak_tag_r, trough_tag_r;
  logic                    any_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      peak_r       <= {1'b1, {(VAL_W-1){1'b0}}};
      trough_r     <= {1'b0, {(VAL_W-1){1'b1}}};
      peak_tag_r   <= '0;
      trough_tag_r <= '0;
      any_r        <= 1'b0;
    end else if (cmd.upd && !sat) begin
      // the first sample after clear always takes both extremes
      if (!any_r || smp_val_r > peak_r) begin
        peak_r     <= smp_val_r;
        peak_tag_r <= smp_tag_r;
      end
      if (!any_r || smp_val_r < trough_r) begin
        trough_r     <= smp_val_r;
        trough_tag_r <= smp_tag_r;
      end
      any_r <= 1'b1;
    end
  end

  // shared serial arithmetic unit
  logic              run_r;
  unit_t             kind_r;
  logic [STEP_W-1:0] step_r;
  logic [NUM_W-1:0]  mc_r, acc_r, pa_r, pb_r, quo_r;
  logic [SUM_W-1:0]  mp_r;
  logic [DEN_W-1:0]  den_r, rem_r;
  logic              neg_r, qsat_r;
  logic signed [VAL_W-1:0] mean_r;
  logic [SX_W-1:0]   sx_r;
  logic [SR_W-1:0]   srem_r;
  logic [RT_W-1:0]   root_r;

  logic [NUM_W-1:0]  acc_nxt, quo_nxt;
  logic [DEN_W:0]    dtry;
  logic              dge;
  logic [DEN_W-1:0]  rem_nxt;
  logic [SR_W+1:0]   srem2, strial;
  logic              sge;

  assign acc_nxt = acc_r + (mp_r[0] ? mc_r : '0);
  assign dtry    = {rem_r, quo_r[NUM_W-1]};
  assign dge     = dtry >= {1'b0, den_r};
  assign rem_nxt = dge ? DEN_W'(dtry - {1'b0, den_r}) : DEN_W'(dtry);
  assign quo_nxt = {quo_r[NUM_W-2:0], dge};
  assign srem2   = {srem_r, sx_r[SX_W-1 -: 2]};
  assign strial  = (SR_W+2)'({root_r, 2'b01});
  assign sge     = srem2 >= strial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (cmd.mul_go || cmd.div_go || cmd.sqrt_go) begin
      run_r <= 1'b1;
    end else if (run_r && step_r == STEP_W'(1)) begin
      run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      kind_r <= cmd.mul_sq ? U_MUL_SQ : U_MUL_MAG;
      mc_r   <= cmd.mul_sq ? NUM_W'(e_sq) : NUM_W'(e_mag);
      mp_r   <= cmd.mul_sq ? SUM_W'(e_cnt) : e_mag;
      acc_r  <= '0;
      step_r <= STEP_W'(SUM_W);
    end else if (cmd.div_go) begin
      kind_r <= cmd.div_var ? U_DIV_VAR : U_DIV_MEAN;
      quo_r  <= cmd.div_var ? pa_r - pb_r : NUM_W'(e_mag);
      den_r  <= cmd.div_var ? DEN_W'(e_cnt) * DEN_W'(e_cnt - COUNT_BITS'(1))
                            : DEN_W'(e_cnt);
      neg_r  <= pa_r < pb_r;
      rem_r  <= '0;
      step_r <= STEP_W'(NUM_W);
    end else if (cmd.sqrt_go) begin
      kind_r <= U_SQRT;
      qsat_r <= |quo_r[NUM_W-1:SX_W];
      sx_r   <= quo_r[SX_W-1:0];
      srem_r <= '0;
      root_r <= '0;
      step_r <= STEP_W'(RT_W);
    end else if (run_r) begin
      step_r <= step_r - STEP_W'(1);
      case (kind_r)
        U_MUL_SQ, U_MUL_MAG: begin
          acc_r <= acc_nxt;
          mc_r  <= {mc_r[NUM_W-2:0], 1'b0};
          mp_r  <= {1'b0, mp_r[SUM_W-1:1]};
          if (step_r == STEP_W'(1)) begin
            if (kind_r == U_MUL_SQ) begin
              pa_r <= acc_nxt;
            end else begin
              pb_r <= acc_nxt;
            end
          end
        end
        U_DIV_MEAN, U_DIV_VAR: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          if (step_r == STEP_W'(1) && kind_r == U_DIV_MEAN) begin
            mean_r <= e_neg ? -signed'(quo_nxt[VAL_W-1:0]) : signed'(quo_nxt[VAL_W-1:0]);
          end
        end
        U_SQRT: begin
          srem_r <= sge ? SR_W'(srem2 - strial) : SR_W'(srem2);
          root_r <= {root_r[RT_W-2:0], sge};
          sx_r   <= {sx_r[SX_W-3:0], 2'b00};
        end
        default: begin
        end
      endcase
    end
  end

  // report bookkeeping
  logic [CFG_W-1:0] n_rep;
  logic             k_last;
  assign n_rep  = (active_r == '0) ? CFG_W'(1)
                : (active_r > CFG_W'(REP_LIM)) ? CFG_W'(REP_LIM) : active_r;
  assign k_last = (7'(rep_ch_r) + 7'd1) == 7'(n_rep);

  // output register
  logic out_valid_r, out_free;
  assign out_free = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_if.report_channel <= RCH_W'(rep_ch_r);
      out_if.mean_value     <= (e_cnt == '0) ? '0 : mean_r;
      out_if.deviation      <= (e_cnt <= COUNT_BITS'(1) || neg_r) ? '0
                             : qsat_r ? '1 : root_r;
      out_if.largest_value  <= peak_r;
      out_if.largest_tag    <= peak_tag_r;
      out_if.smallest_value <= trough_r;
      out_if.smallest_tag   <= trough_tag_r;
      out_if.no_samples     <= !any_r;
      out_if.overflowed     <= e_ovf;
      out_if.last_result    <= k_last;
    end
  end
  assign out_if.valid = out_valid_r;

  assign st.req_valid = in_if.valid;
  assign st.req_op    = in_if.op;
  assign st.ch_ok     = 32'(in_if.channel) < CHANNELS;
  assign st.busy      = run_r;
  assign st.out_free  = out_free;
  assign st.k_last    = k_last;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_go || cmd.div_go || cmd.sqrt_go) |-> !run_r)
    else $error("arithmetic unit restarted while running");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result register overwritten before it was taken");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |=> (!any_r && valid_r == '0))
    else $error("clear left samples behind");

endmodule

>>> rtl/core/multichannel_sample_statistics.sv
// Top level of the multichannel sample statistics block
// Joins msstat_ctrl and msstat_dp; uses msstat_pkg, msstat_in_if, msstat_out_if
//
// Per-channel count, sum and sum of squares live in a small store with a valid bit per
// entry, so a clear item resets the valid bits and extremes. A sample item reads the
// store, then writes the update; a report item runs one channel at a time through a
// shared serial unit: two shift-add multiplies of 24+COUNT_BITS steps, two restoring
// divides of 48+2*COUNT_BITS steps and a 24-step square root. The result register
// lets the next item in while the last result of a report still waits to be taken.
module multichannel_sample_statistics #(
  parameter int CHANNELS   = msstat_pkg::DEF_CHANNELS,
  parameter int COUNT_BITS = msstat_pkg::DEF_COUNT_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [msstat_pkg::CFG_W-1:0] cfg_data,
  msstat_in_if.sink                    in_if,
  msstat_out_if.source                 out_if
);
  import msstat_pkg::*;

  cmd_t  cmd;
  stat_t st;

  msstat_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  msstat_dp #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_if    (in_if),
    .out_if   (out_if),
    .cmd      (cmd),
    .st       (st)
  );

endmodule
